/* rtl/i2d_pkg.sv */
package i2d_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned FracW = 52;
	localparam int unsigned ExpW = 11;
	localparam int unsigned PosW = 6;
	localparam logic [ExpW-1:0] ExpBias = 11'd1023;

	// leading-one search result for one 16-bit quarter
	typedef struct packed {
		logic       any;
		logic [3:0] pos;
	} lz16_t;

	function automatic lz16_t find_msb16(input logic [15:0] v);
		lz16_t r;
		r.any = |v;
		r.pos = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) begin
				r.pos = 4'(i);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/i2d_round.sv */
module i2d_round (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid,
	input  logic                              sign,
	input  logic                              nonzero,
	input  logic [i2d_pkg::PosW-1:0]          pos,
	input  logic [i2d_pkg::WordW-1:0]         norm,
	output logic                              out_valid,
	output logic [i2d_pkg::WordW-1:0]         out_bits
);

	// norm has its leading one at bit 63; bits 10..0 are dropped
	logic [i2d_pkg::FracW:0]   mant;
	logic                      guard;
	logic                      sticky;
	logic                      round_up;
	logic [i2d_pkg::FracW+1:0] mant_r;
	logic [i2d_pkg::ExpW-1:0]  exp_v;
	logic [i2d_pkg::FracW-1:0] frac_v;

	always_comb begin
		mant     = norm[63:11];
		guard    = norm[10];
		sticky   = |norm[9:0];
		round_up = guard & (sticky | mant[0]);
		mant_r   = {1'b0, mant} + {{i2d_pkg::FracW+1{1'b0}}, round_up};
		exp_v    = i2d_pkg::ExpBias + {{(i2d_pkg::ExpW-i2d_pkg::PosW){1'b0}}, pos}
		           + {{(i2d_pkg::ExpW-1){1'b0}}, mant_r[i2d_pkg::FracW+1]};
		frac_v   = mant_r[i2d_pkg::FracW+1] ? mant_r[i2d_pkg::FracW:1]
		                                    : mant_r[i2d_pkg::FracW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid;
		end
	end

	always_ff @(posedge clk) begin
		out_bits <= nonzero ? {sign, exp_v, frac_v} : '0;
	end

endmodule

/* rtl/int64_to_double_convert_top.sv */
// int64 to binary64 converter
// command channel: drive value with start high; busy is always low, so a
// beat is taken on every cycle that start is high
// result channel: double_bits is shown for one cycle with done high; the
// receiver cannot stall and needs none, as every result is final
// throughput: one conversion per cycle through the four register stages
//   s1 magnitude, s2 quarter leading-one search, s3 normalising shift,
//   then rounding and packing into the output register
// rounding is to nearest, ties to even; zero gives +0
// reset clears the stage valid bits only, so nothing is in flight after it
module int64_to_double_convert_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	output logic        done,
	output logic [63:0] double_bits
);

	logic        v_s1, v_s2, v_s3;
	logic        sign_s1, sign_s2, sign_s3;
	logic [63:0] mag_s1, mag_s2;
	i2d_pkg::lz16_t q_s2 [4];
	logic        nz_s3;
	logic [5:0]  pos_s3;
	logic [63:0] norm_s3;

	// coarse and fine leading-one position from the four quarter searches
	logic [5:0]  pos_c;
	logic        nz_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: sign and magnitude
	always_ff @(posedge clk) begin
		sign_s1 <= value[63];
		mag_s1  <= value[63] ? (~value + 64'd1) : value;
	end

	// stage 2: leading-one search per quarter
	always_ff @(posedge clk) begin
		sign_s2 <= sign_s1;
		mag_s2  <= mag_s1;
		for (int i = 0; i < 4; i++) begin
			q_s2[i] <= i2d_pkg::find_msb16(mag_s1[16*i +: 16]);
		end
	end

	always_comb begin
		pos_c = 6'd0;
		nz_c  = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (q_s2[i].any) begin
				pos_c = {2'(i), q_s2[i].pos};
				nz_c  = 1'b1;
			end
		end
	end

	// stage 3: shift leading one up to bit 63
	always_ff @(posedge clk) begin
		sign_s3 <= sign_s2;
		nz_s3   <= nz_c;
		pos_s3  <= pos_c;
		norm_s3 <= mag_s2 << (6'd63 - pos_c);
	end

	// stage 4: round and pack
	i2d_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (v_s3),
		.sign      (sign_s3),
		.nonzero   (nz_s3),
		.pos       (pos_s3),
		.norm      (norm_s3),
		.out_valid (done),
		.out_bits  (double_bits)
	);

endmodule

/* rtl/i2d_checker.sv */
module i2d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [63:0] double_bits
);

	// every beat gives exactly one result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done) else $error("missing result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4)) else $error("spurious result");

	// never negative zero
	a_no_negzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> double_bits != 64'h8000000000000000) else $error("negative zero");

	// exponent never above 2^63
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && double_bits[62:52] != 11'd0 |-> double_bits[62:52] <= 11'd1086)
		else $error("exponent out of range");

endmodule

bind int64_to_double_convert_top i2d_checker u_i2d_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.double_bits (double_bits)
);

/* tb/int64_to_double_convert_checker.sv */
module int64_to_double_convert_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] value,
	input  logic        done,
	input  logic [63:0] double_bits,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0] expected_bits_q[$];

	// signed integer to binary64, round to nearest even
	function automatic logic [63:0] int_to_binary64(input logic [63:0] raw);
		logic        sgn;
		logic [63:0] mag, rem, half;
		logic [63:0] mant;
		logic [10:0] exp_f;
		int          msb, sh;
		sgn = raw[63];
		mag = sgn ? (~raw + 64'd1) : raw;
		if (mag == 64'd0)
			return 64'd0;
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (mag[i]) msb = i;
		exp_f = 11'(1023 + msb);
		if (msb <= 52) begin
			mant = mag << (52 - msb);
		end else begin
			sh = msb - 52;
			rem = mag & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			mant = mag >> sh;
			if (rem > half || (rem == half && mant[0]))
				mant = mant + 64'd1;
			if (mant == (64'd1 << 53)) begin
				mant = mant >> 1;
				exp_f = exp_f + 11'd1;
			end
		end
		return {sgn, exp_f, mant[51:0]};
	endfunction

	assign pending_count = expected_bits_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_bits_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result %h", double_bits);
				end else begin
					if (double_bits !== expected_bits_q[0]) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected %h actual %h",
								expected_bits_q[0], double_bits);
					end
					void'(expected_bits_q.pop_front());
				end
			end
			if (start && !busy)
				expected_bits_q.push_back(int_to_binary64(value));
		end
	end
endmodule

/* tb/int64_to_double_convert_top_tb.sv */
module int64_to_double_convert_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [63:0] value = 64'd0;
	logic        busy, done;
	logic [63:0] double_bits;
	int          fail_count, pending_count;
	int          cycle_count = 0;

	// directed values: extremes, rounding ties, carry-out of the significand
	logic [63:0] directed_values[] = '{
		64'd0, 64'd1, -64'sd1, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
		64'h8000_0000_0000_0001, 64'h001f_ffff_ffff_ffff, 64'h0020_0000_0000_0000,
		64'h0020_0000_0000_0001, 64'h0020_0000_0000_0003, 64'h0040_0000_0000_0002,
		64'h0040_0000_0000_0006, 64'h003f_ffff_ffff_ffff, 64'h7fff_ffff_ffff_fc00,
		64'h7fff_ffff_ffff_fbff, 64'hffdf_ffff_ffff_ffff, 64'h0000_0001_0000_0000,
		64'h0000_0000_ffff_ffff, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
		64'h0000_0000_0001_0000, 64'h0040_0000_0000_0001
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	int64_to_double_convert_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.value(value), .done(done), .double_bits(double_bits)
	);

	int64_to_double_convert_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .value(value),
		.done(done), .double_bits(double_bits),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// random operand, magnitude spread over every bit length
	function automatic logic [63:0] random_value();
		logic [63:0] v;
		int          len;
		v = {$urandom, $urandom};
		len = $urandom_range(64, 1);
		if ($urandom_range(3, 0) != 0 && len < 64)
			v = v & ((64'd1 << len) - 64'd1);
		if ($urandom_range(1, 0))
			v = ~v + 64'd1;
		return v;
	endfunction

	// one beat: optional idle gap, then hold start until taken
	task automatic send_beat(input logic [63:0] v, input int idle_pct);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		int idle_pct;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_values[i])
			send_beat(directed_values[i], 0);
		// phases: no idling, heavy sender idling, light idling, then a random mix of none and heavy
		for (int n = 0; n < 1500; n++) begin
			case (n / 375)
				0: idle_pct = 0;
				1: idle_pct = 67;
				2: idle_pct = 11;
				default: idle_pct = ($urandom_range(1, 0)) ? 0 : 67;
			endcase
			send_beat(random_value(), idle_pct);
		end
		start <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
